// ===== rtl/core/clt_pkg.sv =====
package clt_pkg;

    localparam int LINE_MAX_DEFAULT = 512;

    localparam int CHAR_W = 8;
    localparam int TOK_W  = CHAR_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h5c;

    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP3    = 3'd4;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_EOL    = 2'd1,
        CMD_PULL   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_rd;
        logic scan_proc;
        logic flush;
        logic load_rsp;
        logic clear_ovf;
    } clt_ctl_t;

    typedef struct packed {
        logic scan_last;
    } clt_sts_t;

endpackage

// ===== rtl/core/clt_datapath.sv =====
module clt_datapath
    import clt_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAR_W-1:0]    cfg_data,
    input  logic [1:0]           cmd,
    input  logic [CHAR_W-1:0]    ch,
    input  clt_ctl_t             ctl,
    output clt_sts_t             sts,
    output logic [CHAR_W-1:0]    out_char,
    output logic                 token_last,
    output logic                 out_valid,
    output logic                 line_ready,
    output logic                 overflow
);

    localparam int IDX_W = $clog2(LINE_MAX);
    localparam int CNT_W = $clog2(LINE_MAX + 1);
    localparam logic [CNT_W-1:0] LINE_MAX_CNT = CNT_W'(LINE_MAX);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    logic [CHAR_W-1:0] line_mem [LINE_MAX];
    logic [TOK_W-1:0]  tok_mem  [LINE_MAX];

    logic              special_reg;
    logic [CHAR_W-1:0] sep_reg [4];

    logic [CNT_W-1:0] line_count_reg, line_count_next;
    logic [CNT_W-1:0] token_count_reg, token_count_next;
    logic [CNT_W-1:0] read_index_reg, read_index_next;
    logic             ready_flag_reg, ready_flag_next;
    logic             overflow_flag_reg, overflow_flag_next;
    logic             hit_reg, hit_next;

    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] start_reg, start_next;
    logic             esc_reg, esc_next;
    logic             quoted_reg, quoted_next;
    logic [CHAR_W-1:0] pend_char_reg, pend_char_next;
    logic             pend_last_reg, pend_last_next;

    logic [CHAR_W-1:0] line_rdata_reg;
    logic [TOK_W-1:0]  tok_rdata_reg;

    cmd_t             cmd_code;
    logic             line_we;
    logic             tok_we;
    logic [CNT_W-1:0] n_minus_one;
    logic [CNT_W-1:0] read_index_inc;
    logic [CHAR_W-1:0] scan_char;
    logic             is_sep;
    logic             is_esc;
    logic             is_quote;
    logic             is_break;
    logic             take_char;

    assign cmd_code       = cmd_t'(cmd);
    assign n_minus_one    = n_reg - ONE_CNT;
    assign read_index_inc = read_index_reg + ONE_CNT;
    assign sts.scan_last  = (scan_idx_reg == line_count_reg);

    // Classification of the character under the scan pointer.
    assign scan_char = sts.scan_last ? CH_NUL : line_rdata_reg;
    assign is_sep    = ((sep_reg[0] != CH_NUL) && (sep_reg[0] == scan_char))
                    || ((sep_reg[1] != CH_NUL) && (sep_reg[1] == scan_char))
                    || ((sep_reg[2] != CH_NUL) && (sep_reg[2] == scan_char))
                    || ((sep_reg[3] != CH_NUL) && (sep_reg[3] == scan_char));
    assign is_esc    = !esc_reg && special_reg && (scan_char == CH_ESC);
    assign is_quote  = special_reg && (scan_char == CH_QUOTE);
    assign is_break  = !esc_reg
                    && (is_quote || (!quoted_reg && is_sep) || (scan_char == CH_NUL));
    assign take_char = !is_esc && !is_break && (scan_char != CH_NUL);

    assign line_we = ctl.accept && (cmd_code == CMD_APPEND)
                  && !(special_reg && (ch == CH_BS)) && (ch != CH_NUL)
                  && (line_count_reg < LINE_MAX_CNT);

    // The newest token character is held aside until its last mark is known.
    assign tok_we = (n_reg != '0) && ((ctl.scan_proc && take_char) || ctl.flush);

    always_comb
    begin
        line_count_next    = line_count_reg;
        token_count_next   = token_count_reg;
        read_index_next    = read_index_reg;
        ready_flag_next    = ready_flag_reg;
        overflow_flag_next = overflow_flag_reg;
        hit_next           = hit_reg;
        scan_idx_next      = scan_idx_reg;
        n_next             = n_reg;
        start_next         = start_reg;
        esc_next           = esc_reg;
        quoted_next        = quoted_reg;
        pend_char_next     = pend_char_reg;
        pend_last_next     = pend_last_reg;

        if (ctl.accept)
        begin
            hit_next = (cmd_code == CMD_PULL) && ready_flag_reg;
            if (cmd_code == CMD_APPEND)
            begin
                if (special_reg && (ch == CH_BS))
                begin
                    if (line_count_reg != '0)
                    begin
                        line_count_next = line_count_reg - ONE_CNT;
                    end
                end
                else if (ch != CH_NUL)
                begin
                    if (line_count_reg < LINE_MAX_CNT)
                    begin
                        line_count_next = line_count_reg + ONE_CNT;
                    end
                    else
                    begin
                        overflow_flag_next = 1'b1;
                    end
                end
            end
            if ((cmd_code == CMD_PULL) && ready_flag_reg)
            begin
                read_index_next = read_index_inc;
                ready_flag_next = (read_index_inc < token_count_reg);
            end
        end

        if (ctl.scan_start)
        begin
            scan_idx_next = '0;
            n_next        = '0;
            start_next    = '0;
            esc_next      = 1'b0;
            quoted_next   = 1'b0;
        end

        if (ctl.scan_proc)
        begin
            scan_idx_next = scan_idx_reg + ONE_CNT;
            if (is_esc)
            begin
                esc_next = 1'b1;
            end
            else if (is_break)
            begin
                if (is_quote)
                begin
                    quoted_next = !quoted_reg;
                end
                if (!(is_quote && !quoted_reg))
                begin
                    if (n_reg > start_reg)
                    begin
                        pend_last_next = 1'b1;
                    end
                    start_next = n_reg;
                end
            end
            else
            begin
                if (scan_char != CH_NUL)
                begin
                    pend_char_next = scan_char;
                    pend_last_next = 1'b0;
                    n_next         = n_reg + ONE_CNT;
                end
                esc_next = 1'b0;
            end
        end

        if (ctl.flush)
        begin
            token_count_next = start_reg;
            read_index_next  = '0;
            ready_flag_next  = (start_reg != '0);
            line_count_next  = '0;
        end

        if (ctl.clear_ovf)
        begin
            overflow_flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            special_reg       <= 1'b1;
            sep_reg[0]        <= 8'd32;
            sep_reg[1]        <= CH_NUL;
            sep_reg[2]        <= CH_NUL;
            sep_reg[3]        <= CH_NUL;
            line_count_reg    <= '0;
            token_count_reg   <= '0;
            read_index_reg    <= '0;
            ready_flag_reg    <= 1'b0;
            overflow_flag_reg <= 1'b0;
            hit_reg           <= 1'b0;
            scan_idx_reg      <= '0;
            n_reg             <= '0;
            start_reg         <= '0;
            esc_reg           <= 1'b0;
            quoted_reg        <= 1'b0;
            pend_last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SPECIAL: special_reg <= cfg_data[0];
                    CFG_SEP0:    sep_reg[0]  <= cfg_data;
                    CFG_SEP1:    sep_reg[1]  <= cfg_data;
                    CFG_SEP2:    sep_reg[2]  <= cfg_data;
                    CFG_SEP3:    sep_reg[3]  <= cfg_data;
                    default:     special_reg <= special_reg;
                endcase
            end
            line_count_reg    <= line_count_next;
            token_count_reg   <= token_count_next;
            read_index_reg    <= read_index_next;
            ready_flag_reg    <= ready_flag_next;
            overflow_flag_reg <= overflow_flag_next;
            hit_reg           <= hit_next;
            scan_idx_reg      <= scan_idx_next;
            n_reg             <= n_next;
            start_reg         <= start_next;
            esc_reg           <= esc_next;
            quoted_reg        <= quoted_next;
            pend_last_reg     <= pend_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_char_reg <= pend_char_next;
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_count_reg[IDX_W-1:0]] <= ch;
        end
        if (ctl.scan_rd)
        begin
            line_rdata_reg <= line_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_we)
        begin
            tok_mem[n_minus_one[IDX_W-1:0]] <= {pend_last_reg, pend_char_reg};
        end
        if (ctl.accept && (cmd_code == CMD_PULL))
        begin
            tok_rdata_reg <= tok_mem[read_index_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_rsp)
        begin
            out_char   <= hit_reg ? tok_rdata_reg[CHAR_W-1:0] : CH_NUL;
            token_last <= hit_reg && tok_rdata_reg[CHAR_W];
            out_valid  <= hit_reg;
            line_ready <= ready_flag_reg;
            overflow   <= overflow_flag_reg;
        end
    end

endmodule

// ===== rtl/core/clt_controller.sv =====
module clt_controller
    import clt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [1:0] cmd,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  clt_sts_t   sts,
    output clt_ctl_t   ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_PROC,
        ST_FLUSH,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   tok_reg, tok_next;
    cmd_t   cmd_code;

    assign cmd_code  = cmd_t'(cmd);
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        tok_next       = tok_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.accept = 1'b1;
                    tok_next   = (cmd_code == CMD_EOL);
                    if (cmd_code == CMD_EOL)
                    begin
                        ctl.scan_start = 1'b1;
                        state_next     = ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                ctl.scan_rd = 1'b1;
                state_next  = ST_SCAN_PROC;
            end
            ST_SCAN_PROC:
            begin
                ctl.scan_proc = 1'b1;
                state_next    = sts.scan_last ? ST_FLUSH : ST_SCAN_RD;
            end
            ST_FLUSH:
            begin
                ctl.flush  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.load_rsp   = 1'b1;
                    ctl.clear_ovf  = tok_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            tok_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            tok_reg       <= tok_next;
        end
    end

endmodule

// ===== rtl/core/command_line_tokenizer.sv =====
// Shell-style command line tokenizer. Each request carries a command: append a
// character to the line, end the line and split it into tokens, or pull the next
// token character; every request returns exactly one response. Append, pull and
// no-op requests are taken, then the response register is loaded. End of line runs
// a scan loop over the L kept characters of the line: each character is read from
// the line memory and then classified, one character at a time, and after the
// loop the tokens are flushed and the response register is loaded. A new request is taken while
// an earlier response still waits in the output register; the response of that
// request is held back until the output register is free.
module command_line_tokenizer
    import clt_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAR_W-1:0]    cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           cmd,
    input  logic [CHAR_W-1:0]    ch,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [CHAR_W-1:0]    out_char,
    output logic                 token_last,
    output logic                 out_valid,
    output logic                 line_ready,
    output logic                 overflow
);

    clt_ctl_t ctl;
    clt_sts_t sts;

    clt_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    clt_datapath #(
        .LINE_MAX (LINE_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .ch         (ch),
        .ctl        (ctl),
        .sts        (sts),
        .out_char   (out_char),
        .token_last (token_last),
        .out_valid  (out_valid),
        .line_ready (line_ready),
        .overflow   (overflow)
    );

endmodule
